// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal text block.
`default_nettype none

package sida_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int STEP_W     = $clog2(VALUE_W + 1);
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int CHAR_W     = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/sida_dabble.sv =====
// Iterative shift-and-add-3 converter: 32-bit magnitude to ten BCD digits.
`default_nettype none

module sida_dabble (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [sida_pkg::VALUE_W-1:0]   magnitude,
   output sida_pkg::status_type                status,
   output logic      [sida_pkg::BCD_W-1:0]     bcd
);
   import sida_pkg::*;

   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [STEP_W-1:0]  count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BCD_W-1:0]   corrected;

   // Correct every digit of five or more, then shift one bit in.
   always_comb begin
      corrected = bcd_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            corrected[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = magnitude;
         bcd_in   = '0;
         count_in = STEP_W'(VALUE_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {corrected[BCD_W-2:0], shift_ff[VALUE_W-1]};
         count_in = count_ff - STEP_W'(1);
         done_in  = (count_ff == STEP_W'(1));
         busy_in  = (count_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII characters, one word each.
// Sequence: the first character is loaded after the 32 shift-and-add-3 steps
//   in the BCD unit, the ST_CONVERT step that finds the leading digit, and
//   the load of the output register.
// Throughput: one character per cycle after that while rsp_ready stays high;
//   req_ready is high only while idle.
// Reset: synchronous, active high; clears the sequencer, the BCD unit control
//   and rsp_valid. Payload registers are not reset.
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [sida_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [sida_pkg::CHAR_W-1:0]   rsp_character,
   output logic                               rsp_last
);
   import sida_pkg::*;

   state_type          state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_character_ff, rsp_character_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               start;
   logic [VALUE_W-1:0] magnitude;
   status_type         status;
   logic [BCD_W-1:0]   bcd;
   logic [IDX_W-1:0]   msd;
   logic [DIGIT_W-1:0] digit;
   logic               slot_free;

   // Magnitude through a 32-bit negation: the most negative value maps to 2^31.
   assign magnitude = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;

   sida_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .magnitude (magnitude),
      .status    (status),
      .bcd       (bcd)
   );

   // Position of the most significant nonzero digit; zero renders as one '0'.
   always_comb begin
      msd = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
            msd = IDX_W'(i);
         end
      end
   end

   assign digit     = bcd[{idx_ff, 2'b00} +: DIGIT_W];
   // The output register may take a new word when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      neg_in           = neg_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      req_ready        = 1'b0;
      start            = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Capture the sign and hand the magnitude to the BCD unit.
               neg_in   = req_value[VALUE_W-1];
               start    = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.done) begin
               idx_in   = msd;
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               // Emit digits most significant first; the units digit ends the text.
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_ZERO + CHAR_W'(digit);
               rsp_last_in      = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff           <= neg_in;
      idx_ff           <= idx_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // The BCD unit finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      status.done |-> state_ff == ST_CONVERT)
      else $error("BCD unit finished outside conversion");

   // The BCD unit is quiet whenever the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !status.busy)
      else $error("BCD unit busy while idle");

   // The digit index never leaves the ten-digit range.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGITS |-> idx_ff <= IDX_W'(NUM_DIGITS - 1))
      else $error("digit index out of range");

   // A last word is always a decimal digit, never the minus sign.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         rsp_character_ff >= CHAR_ZERO && rsp_character_ff <= CHAR_NINE)
      else $error("last word is not a digit");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the signed integer to decimal ASCII converter: predicts each character and checks.
`timescale 1ns / 1ps

module tb;

   import sida_pkg::*;

   // One expected character of a rendered value.
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last;

   // Characters still owed by the block, oldest first.
   text_char_type pending_text[$];

   int mismatch_count = 0;
   // Suspend random idling on both sides while set.
   bit quiet = 1'b0;
   // Ask the receiver to hold off for this many cycles; it takes the request over.
   int hold_request = 0;
   int hold_left = 0;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // Render a value as decimal text and queue its characters, sign first.
   function automatic void render_decimal(logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] magnitude;
      logic [DIGIT_W-1:0] digit_lsf[NUM_DIGITS];
      int                 n_digits;
      text_char_type      c;
      magnitude = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
      n_digits = 0;
      // Collect digits least significant first; zero still gives one digit.
      do begin
         digit_lsf[n_digits] = DIGIT_W'(magnitude % 10);
         magnitude = magnitude / 10;
         n_digits++;
      end while (magnitude != 0 && n_digits < NUM_DIGITS);
      if (raw[VALUE_W-1]) begin
         c.code = CHAR_MINUS;
         c.last = 1'b0;
         pending_text.push_back(c);
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
         c.code = CHAR_ZERO + CHAR_W'(digit_lsf[i]);
         c.last = (i == 0);
         pending_text.push_back(c);
      end
   endfunction

   // Predict on each accepted value, then check each accepted character
   // against the oldest expectation. Both sampled at the rising edge.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            render_decimal(req_value);
         if (rsp_valid && rsp_ready) begin
            if (pending_text.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected character %0d last %0b", rsp_character, rsp_last);
            end else begin
               want = pending_text.pop_front();
               if (rsp_character !== want.code || rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                              want.code, want.last, rsp_character, rsp_last);
               end
            end
         end
      end
   end

   // Receiver: stall at random, or hold off for a requested stretch.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 25);
      end
   end

   // Offer one word; entered and left at a falling edge. Valid is not lowered
   // on return, so back-to-back words keep it high without a glitch.
   task automatic send_value(logic signed [VALUE_W-1:0] v);
      int gap;
      gap = 0;
      while (!quiet && $urandom_range(99) < 25)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Drop valid and hold the sender until every character has come back.
   task automatic drain_text();
      req_valid <= 1'b0;
      while (pending_text.size() != 0)
         @(negedge clock);
   endtask

   // Pick a value of a random decimal length and sign; full range at length ten.
   function automatic logic signed [VALUE_W-1:0] value_of_length();
      int unsigned lo;
      int unsigned hi;
      int unsigned mag;
      int          n;
      bit          neg;
      n = $urandom_range(10, 1);
      neg = 1'($urandom_range(1));
      lo = (n == 1) ? 0 : 1;
      for (int i = 1; i < n; i++)
         lo = lo * 10;
      hi = (n == 10) ? (neg ? 32'h8000_0000 : 32'h7fff_ffff) : lo * 10 - 1;
      if (n == 1)
         hi = 9;
      mag = $urandom_range(hi, lo);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // Field extremes, several length boundaries, zero and the most negative value.
   task automatic test_directed();
      send_value(32'sd0);
      send_value(32'sd1);
      send_value(-32'sd1);
      send_value(32'sd9);
      send_value(32'sd10);
      send_value(-32'sd10);
      send_value(32'sd99);
      send_value(32'sd100);
      send_value(-32'sd101);
      send_value(32'sd999999999);
      send_value(-32'sd999999999);
      send_value(32'sd1000000000);
      send_value(-32'sd1000000000);
      send_value(32'sh7fff_ffff);
      send_value(32'sh8000_0000);
      send_value(32'sh8000_0001);
      send_value(32'sh5555_5555);
      send_value(32'shaaaa_aaaa);
      send_value(32'sh0000_ffff);
      send_value(32'shffff_0000);
   endtask

   // Pause the sender until the block is empty, then resume.
   task automatic test_sender_pause();
      drain_text();
      repeat (5) send_value(value_of_length());
      drain_text();
   endtask

   // Stall the receiver for a long stretch while offering words, so the
   // block fills and holds its input off.
   task automatic test_receiver_hold();
      hold_request = 300;
      repeat (8) send_value(value_of_length());
   endtask

   // Random values, mostly by decimal length, some raw 32-bit patterns;
   // run one stretch with idling off on both sides.
   task automatic test_random(int count);
      for (int k = 0; k < count; k++) begin
         quiet = (k >= count / 2 && k < count / 2 + 40);
         if ($urandom_range(3) == 0)
            send_value($signed($urandom));
         else
            send_value(value_of_length());
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_sender_pause();
      test_receiver_hold();
      test_random(190);

      // Let the block finish, then watch a while for stray characters.
      drain_text();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_text.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
